FILE: rtl/fssr_pkg.sv
`timescale 1ns / 1ps
package fssr_pkg;

  localparam int DEF_MAX_POINTS = 256;

  // divider operand widths: 24-bit dividend covers (v - min) << 16
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 10;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_POLL  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_RAW   = 2'd3;

  localparam logic [1:0] RUN_OFF  = 2'd0;
  localparam logic [1:0] RUN_ON   = 2'd1;
  localparam logic [1:0] RUN_DONE = 2'd2;

  localparam logic [2:0] CFG_BAND_LOW    = 3'd0;
  localparam logic [2:0] CFG_BAND_HIGH   = 3'd1;
  localparam logic [2:0] CFG_SCAN_STEP   = 3'd2;
  localparam logic [2:0] CFG_POINT_LIMIT = 3'd3;
  localparam logic [2:0] CFG_ANCHOR_MODE = 3'd4;

  typedef enum logic [1:0] {
    DIV_ANCHOR,
    DIV_INDEX,
    DIV_RSSI,
    DIV_SNR
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     poll;
    logic     div_go;
    div_sel_t div_sel;
    logic     mul1;
    logic     mul2;
    logic     sfin;
    logic     rd_idx;
    logic     rd_raw;
    logic     cap_raw;
    logic     cap_entry;
    logic     lvl_r;
    logic     lvl_s;
    logic     out_load;
  } fssr_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       anchor_mode;
    logic       hit;
    logic       div_done;
  } fssr_stat_t;

endpackage

FILE: rtl/frequency_sweep_signal_recorder.sv
`timescale 1ns / 1ps
// A query runs three divisions in turn: frequency to index, RSSI level, SNR level.
// Start: from-start mode uses no division; centred runs one division, two multiplies.
// One item at a time; the shared iterative divider sets the query rate.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): sweep off, trackers cleared, config at defaults;
// the point store is not cleared, only points of the current sweep are read.
module frequency_sweep_signal_recorder
  import fssr_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // anchor_freq[15:0], tune_complete[16], radio_freq[32:17], meas_rssi[40:33],
  // meas_snr[48:41], stop_request[49], query_freq[65:50], point_index[73:66]
  input  logic [79:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tune_cmd_valid[0], tune_freq[16:1], scan_state[18:17], data_valid[19],
  // raw_rssi[27:20], raw_snr[35:28], rssi_level[51:36], snr_level[67:52],
  // points_taken[76:68], first_freq[92:77]
  output logic [95:0] m_tdata,
  // scan_finished
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers; the user writes them only while the block is idle (not enforced)
  logic [15:0] band_low, band_high;
  logic [9:0]  scan_step;
  logic [8:0]  point_limit;
  logic        anchor_mode;

  fssr_cmd_t  cmd;
  fssr_stat_t stat;

  logic        tune_cmd_valid, data_valid;
  logic [15:0] tune_freq, rssi_level, snr_level, first_freq;
  logic [1:0]  scan_state;
  logic [7:0]  raw_rssi, raw_snr;
  logic [8:0]  points_taken;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low    <= 16'h0000;
      band_high   <= 16'hffff;
      scan_step   <= 10'd10;
      point_limit <= 9'd200;
      anchor_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BAND_LOW:    band_low    <= cfg_data;
        CFG_BAND_HIGH:   band_high   <= cfg_data;
        CFG_SCAN_STEP:   scan_step   <= cfg_data[9:0];
        CFG_POINT_LIMIT: point_limit <= cfg_data[8:0];
        CFG_ANCHOR_MODE: anchor_mode <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // sequencer: one item at a time, hands the result to the output register
  fssr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // sweep state, point store, divider and result register
  fssr_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .band_low       (band_low),
    .band_high      (band_high),
    .scan_step      (scan_step),
    .point_limit    (point_limit),
    .anchor_mode    (anchor_mode),
    .in_action      (s_tuser),
    .in_anchor      (s_tdata[15:0]),
    .in_tdone       (s_tdata[16]),
    .in_rfreq       (s_tdata[32:17]),
    .in_rssi        (s_tdata[40:33]),
    .in_snr         (s_tdata[48:41]),
    .in_stop        (s_tdata[49]),
    .in_qfreq       (s_tdata[65:50]),
    .in_pidx        (s_tdata[73:66]),
    .tune_cmd_valid (tune_cmd_valid),
    .tune_freq      (tune_freq),
    .scan_state     (scan_state),
    .scan_finished  (m_tlast),
    .data_valid     (data_valid),
    .raw_rssi       (raw_rssi),
    .raw_snr        (raw_snr),
    .rssi_level     (rssi_level),
    .snr_level      (snr_level),
    .points_taken   (points_taken),
    .first_freq     (first_freq)
  );

  assign m_tdata = {3'b000, first_freq, points_taken, snr_level, rssi_level,
                    raw_snr, raw_rssi, data_valid, scan_state, tune_freq,
                    tune_cmd_valid};

endmodule

FILE: rtl/fssr_ram.sv
`timescale 1ns / 1ps
module fssr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fssr_div.sv
`timescale 1ns / 1ps
module fssr_div
  import fssr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] dreg;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] qr;
  logic [CNTW-1:0]   cnt;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW+1:0] dif;

  // one quotient bit per cycle, restoring
  assign sh  = {rem, qr[DIV_NW-1]};
  assign dif = {1'b0, sh} - {2'b00, dreg};
  assign quo = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DIV_NW);
        rem  <= '0;
        qr   <= num;
        dreg <= den;
      end else if (busy) begin
        if (!dif[DIV_DW+1]) begin
          rem <= dif[DIV_DW-1:0];
          qr  <= {qr[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= sh[DIV_DW-1:0];
          qr  <= {qr[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/fssr_ctrl.sv
`timescale 1ns / 1ps
module fssr_ctrl
  import fssr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fssr_stat_t stat,
  output fssr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SDIV, S_MUL1, S_MUL2, S_SFIN, S_QDIV, S_QRD,
    S_QWAIT, S_LR0, S_LDR, S_LDS, S_RWAIT, S_FIN
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_ANCHOR;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.act)
          ACT_START: begin
            if (stat.anchor_mode) begin
              state_next = S_SFIN;
            end else begin
              cmd.div_go  = 1'b1;
              cmd.div_sel = DIV_ANCHOR;
              state_next  = S_SDIV;
            end
          end
          ACT_POLL: begin
            cmd.poll   = 1'b1;
            state_next = S_FIN;
          end
          ACT_QUERY: begin
            if (stat.hit) begin
              cmd.div_go  = 1'b1;
              cmd.div_sel = DIV_INDEX;
              state_next  = S_QDIV;
            end else begin
              state_next = S_FIN;
            end
          end
          default: begin
            if (stat.hit) begin
              cmd.rd_raw = 1'b1;
              state_next = S_RWAIT;
            end else begin
              state_next = S_FIN;
            end
          end
        endcase
      end
      S_SDIV: if (stat.div_done) state_next = S_MUL1;
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_SFIN;
      end
      S_SFIN: begin
        cmd.sfin   = 1'b1;
        state_next = S_FIN;
      end
      S_QDIV: if (stat.div_done) state_next = S_QRD;
      S_QRD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_QWAIT;
      end
      S_QWAIT: begin
        cmd.cap_entry = 1'b1;
        state_next    = S_LR0;
      end
      S_LR0: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_RSSI;
        state_next  = S_LDR;
      end
      S_LDR: begin
        if (stat.div_done) begin
          cmd.lvl_r   = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_SNR;
          state_next  = S_LDS;
        end
      end
      S_LDS: begin
        if (stat.div_done) begin
          cmd.lvl_s  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_RWAIT: begin
        cmd.cap_raw = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDR && stat.div_done) |=> (state == S_LDS))
    else $error("level sequence out of order");
`endif

endmodule

FILE: rtl/fssr_dp.sv
`timescale 1ns / 1ps
module fssr_dp
  import fssr_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  input  fssr_cmd_t   cmd,
  output fssr_stat_t  stat,
  input  logic [15:0] band_low,
  input  logic [15:0] band_high,
  input  logic [9:0]  scan_step,
  input  logic [8:0]  point_limit,
  input  logic        anchor_mode,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_anchor,
  input  logic        in_tdone,
  input  logic [15:0] in_rfreq,
  input  logic [7:0]  in_rssi,
  input  logic [7:0]  in_snr,
  input  logic        in_stop,
  input  logic [15:0] in_qfreq,
  input  logic [7:0]  in_pidx,
  output logic        tune_cmd_valid,
  output logic [15:0] tune_freq,
  output logic [1:0]  scan_state,
  output logic        scan_finished,
  output logic        data_valid,
  output logic [7:0]  raw_rssi,
  output logic [7:0]  raw_snr,
  output logic [15:0] rssi_level,
  output logic [15:0] snr_level,
  output logic [8:0]  points_taken,
  output logic [15:0] first_freq
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int SPW = DIV_DW + CW;
  localparam int EW  = (SPW + 1 > 17) ? SPW + 1 : 17;
  localparam int P1W = DIV_DW + 1 + 18;
  localparam int P2W = DIV_DW + 1 + CW + 1;

  // latched item
  logic [1:0]  act;
  logic [15:0] anchor, rfreq, qfreq;
  logic        tdone, stop;
  logic [7:0]  rssi, snr, pidx;

  // sweep state
  logic [1:0]     run_state;
  logic [15:0]    sweep_start;
  logic [CW-1:0]  count;
  logic [CW-1:0]  limit;
  logic [DIV_DW-1:0] step;
  logic [SPW-1:0] span;
  logic [7:0]     min_s, max_s, min_r, max_r;

  // result being built
  logic        tv, fin, dv;
  logic [15:0] tf, lr, ls;
  logic [7:0]  rr, rs;
  logic [15:0] entry;

  logic signed [P1W-1:0] prod1;
  logic signed [P2W-1:0] prod2;

  logic [DIV_DW-1:0] eff_step;
  logic [CW-1:0]     eff_lim;
  logic              div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic [15:0]     cur_f;
  logic [16:0]     nxt_f;
  logic [CW-1:0]   count_inc;
  logic [EW-1:0]   end_f;
  logic            hit_q, hit_raw;
  logic            store_we;
  logic [AW-1:0]   raddr;
  logic [15:0]     rdata;

  logic signed [17:0]  dq;
  logic signed [CW:0]  lm1;
  logic signed [31:0]  p1x, p2x, sum_x, hi_x, lo_x, first_x;
  logic [15:0]         clamp_a;

  assign eff_step = (scan_step == '0) ? DIV_DW'(1) : scan_step;
  assign eff_lim  = (32'(point_limit) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_limit);

  assign cur_f     = sweep_start + 16'(span);
  assign nxt_f     = {1'b0, cur_f} + 17'(step);
  assign count_inc = count + CW'(1);
  assign end_f     = EW'(sweep_start) + EW'(span);
  assign hit_q     = (run_state == RUN_DONE) && (qfreq >= sweep_start) &&
                     (EW'(qfreq) < end_f);
  assign hit_raw   = (run_state == RUN_DONE) && (32'(pidx) < 32'(count));

  assign stat.act         = act;
  assign stat.anchor_mode = anchor_mode;
  assign stat.hit         = (act == ACT_QUERY) ? hit_q : hit_raw;
  assign stat.div_done    = div_done;

  // divider operands
  always_comb begin
    case (cmd.div_sel)
      DIV_ANCHOR: begin
        div_num = DIV_NW'(anchor);
        div_den = eff_step;
      end
      DIV_INDEX: begin
        div_num = DIV_NW'(qfreq - sweep_start);
        div_den = step;
      end
      DIV_RSSI: begin
        div_num = {entry[7:0] - min_s, 16'h0000};
        div_den = DIV_DW'({2'b00, max_s} - {2'b00, min_s} + 10'd1);
      end
      default: begin
        div_num = {entry[15:8] - min_r, 16'h0000};
        div_den = DIV_DW'({2'b00, max_r} - {2'b00, min_r} + 10'd1);
      end
    endcase
  end

  fssr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign store_we = cmd.poll && (run_state == RUN_ON) && (count < limit) &&
                    tdone && (rfreq == cur_f);
  assign raddr    = cmd.rd_raw ? AW'(pidx) : AW'(div_quo);

  fssr_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(count)),
    .wdata ({snr, rssi}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // start arithmetic, signed
  assign dq      = $signed({2'b00, div_quo[15:0]}) - $signed(18'(eff_lim >> 1));
  assign lm1     = $signed({1'b0, eff_lim}) - $signed((CW+1)'(1));
  assign p1x     = prod1;
  assign p2x     = prod2;
  assign sum_x   = p1x + p2x;
  assign hi_x    = $signed({16'h0000, band_high});
  assign lo_x    = $signed({16'h0000, band_low});
  always_comb begin
    first_x = (sum_x > hi_x) ? (hi_x - p2x) : p1x;
    if (first_x < lo_x) begin
      first_x = lo_x;
    end
    clamp_a = (anchor < band_low) ? band_low : anchor;
    if (clamp_a > band_high) begin
      clamp_a = band_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state   <= RUN_OFF;
      sweep_start <= '0;
      count       <= '0;
      limit       <= '0;
      step        <= DIV_DW'(1);
      span        <= '0;
      min_s       <= 8'hff;
      max_s       <= '0;
      min_r       <= 8'hff;
      max_r       <= '0;
    end else begin
      if (cmd.sfin) begin
        sweep_start <= anchor_mode ? clamp_a : first_x[15:0];
        step        <= eff_step;
        limit       <= eff_lim;
        count       <= '0;
        span        <= '0;
        min_s       <= 8'hff;
        max_s       <= '0;
        min_r       <= 8'hff;
        max_r       <= '0;
        run_state   <= RUN_ON;
      end
      if (cmd.poll && run_state == RUN_ON) begin
        if (count >= limit) begin
          run_state <= RUN_DONE;
        end else if (store_we) begin
          if (rssi < min_s) min_s <= rssi;
          if (rssi > max_s) max_s <= rssi;
          if (snr < min_r) min_r <= snr;
          if (snr > max_r) max_r <= snr;
          count <= count_inc;
          span  <= span + SPW'(step);
          if (count_inc >= limit || nxt_f < {1'b0, band_low} ||
              nxt_f > {1'b0, band_high} || stop) begin
            run_state <= RUN_DONE;
          end
        end
      end
    end
  end

  // item latch, products and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= in_action;
      anchor <= in_anchor;
      tdone  <= in_tdone;
      rfreq  <= in_rfreq;
      rssi   <= in_rssi;
      snr    <= in_snr;
      stop   <= in_stop;
      qfreq  <= in_qfreq;
      pidx   <= in_pidx;
      tv     <= 1'b0;
      tf     <= '0;
      fin    <= 1'b0;
      dv     <= 1'b0;
      rr     <= '0;
      rs     <= '0;
      lr     <= '0;
      ls     <= '0;
    end
    if (cmd.mul1) begin
      prod1 <= $signed({1'b0, eff_step}) * dq;
    end
    if (cmd.mul2) begin
      prod2 <= $signed({1'b0, eff_step}) * lm1;
    end
    if (cmd.poll && run_state == RUN_ON) begin
      if (count >= limit) begin
        fin <= 1'b1;
      end else if (tdone) begin
        if (rfreq != cur_f) begin
          tv <= 1'b1;
          tf <= cur_f;
        end else if (count_inc >= limit || nxt_f < {1'b0, band_low} ||
                     nxt_f > {1'b0, band_high} || stop) begin
          fin <= 1'b1;
        end else begin
          tv <= 1'b1;
          tf <= nxt_f[15:0];
        end
      end
    end
    if (cmd.cap_raw) begin
      dv <= 1'b1;
      rr <= rdata[7:0];
      rs <= rdata[15:8];
    end
    if (cmd.cap_entry) begin
      dv    <= 1'b1;
      entry <= rdata;
    end
    if (cmd.lvl_r) begin
      lr <= (entry[7:0] < min_s || max_s < min_s) ? 16'h0000 : div_quo[15:0];
    end
    if (cmd.lvl_s) begin
      ls <= (entry[15:8] < min_r || max_r < min_r) ? 16'h0000 : div_quo[15:0];
    end
    if (cmd.out_load) begin
      tune_cmd_valid <= tv;
      tune_freq      <= tf;
      scan_state     <= run_state;
      scan_finished  <= fin;
      data_valid     <= dv;
      raw_rssi       <= rr;
      raw_snr        <= rs;
      rssi_level     <= lr;
      snr_level      <= ls;
      points_taken   <= 9'(count);
      first_freq     <= sweep_start;
    end
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !div_busy)
    else $error("divider restarted while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_POINTS))
    else $error("point count beyond store depth");
  a_minmax: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (min_s <= max_s && min_r <= max_r))
    else $error("min/max trackers crossed");
`endif

endmodule

FILE: tb/tb_frequency_sweep_signal_recorder.sv
`timescale 1ns / 1ps
module tb_frequency_sweep_signal_recorder;
  import fssr_pkg::*;

  // One input beat, split into the fields that the bench packs into tuser/tdata.
  typedef struct {
    logic [1:0]  action;
    logic [15:0] anchor;
    logic        tdone;
    logic [15:0] rfreq;
    logic [7:0]  rssi;
    logic [7:0]  snr;
    logic        stop;
    logic [15:0] qfreq;
    logic [7:0]  pidx;
  } sweep_item_t;

  // One output beat, field by field.
  typedef struct {
    logic        tv;
    logic [15:0] tf;
    logic [1:0]  state;
    logic        fin;
    logic        dv;
    logic [7:0]  rr;
    logic [7:0]  rs;
    logic [15:0] lr;
    logic [15:0] ls;
    logic [8:0]  pts;
    logic [15:0] first;
  } sweep_report_t;

  // Directed row: an item plus, where it is obvious, the report typed in by hand.
  typedef struct {
    sweep_item_t   it;
    bit            typed;
    sweep_report_t rep;
  } sweep_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  frequency_sweep_signal_recorder u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block: configuration, sweep state and point store.
  logic [15:0] band_low, band_high;
  logic [9:0]  scan_step;
  logic [8:0]  point_limit;
  logic        anchor_mode;
  logic [1:0]  run_state;
  logic [15:0] sweep_start;
  logic [8:0]  point_count;
  logic [7:0]  min_rssi, max_rssi, min_snr, max_snr;
  logic [15:0] point_store [256];
  int unsigned sweep_step, sweep_limit;

  sweep_report_t expected_reports[$];
  int  errors;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] level(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo || hi < lo) return 16'd0;
    return 16'(((v - lo) << 16) / (hi - lo + 1));
  endfunction

  function automatic logic [15:0] sweep_freq();
    return 16'(sweep_start + sweep_step * point_count);
  endfunction

  task automatic apply_register(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_BAND_LOW:    band_low = val;
      CFG_BAND_HIGH:   band_high = val;
      CFG_SCAN_STEP:   scan_step = val[9:0];
      CFG_POINT_LIMIT: point_limit = val[8:0];
      CFG_ANCHOR_MODE: anchor_mode = val[0];
      default: ;
    endcase
  endtask

  // Advance the shadow state by one item and return the report it causes.
  function automatic sweep_report_t record_step(sweep_item_t it);
    sweep_report_t r;
    longint st, pts, first;
    int unsigned f, nf, span_end, idx;
    logic [15:0] e;
    r = '{default: '0};
    case (it.action)
      ACT_START: begin
        sweep_step = (scan_step != 0) ? scan_step : 1;
        sweep_limit = (point_limit > 256) ? 256 : point_limit;
        st = sweep_step;
        pts = sweep_limit;
        if (anchor_mode == 1'b0) begin
          first = st * (longint'(it.anchor / sweep_step) - pts / 2);
          if (first + st * (pts - 1) > longint'(band_high)) first = band_high - st * (pts - 1);
          if (first < longint'(band_low)) first = band_low;
          sweep_start = first[15:0];
        end else begin
          sweep_start = it.anchor;
          if (sweep_start < band_low) sweep_start = band_low;
          if (sweep_start > band_high) sweep_start = band_high;
        end
        point_count = '0;
        min_rssi = 8'hff; max_rssi = '0;
        min_snr = 8'hff; max_snr = '0;
        run_state = RUN_ON;
      end
      ACT_POLL: begin
        if (run_state == RUN_ON) begin
          if (point_count >= sweep_limit) begin
            run_state = RUN_DONE;
            r.fin = 1'b1;
          end else if (it.tdone) begin
            f = sweep_freq();
            if (it.rfreq != f) begin
              r.tv = 1'b1;
              r.tf = f[15:0];
            end else begin
              point_store[point_count[7:0]] = {it.snr, it.rssi};
              if (it.rssi < min_rssi) min_rssi = it.rssi;
              if (it.rssi > max_rssi) max_rssi = it.rssi;
              if (it.snr < min_snr) min_snr = it.snr;
              if (it.snr > max_snr) max_snr = it.snr;
              nf = f + sweep_step;
              point_count++;
              if (point_count >= sweep_limit || nf < band_low || nf > band_high || it.stop)
              begin
                run_state = RUN_DONE;
                r.fin = 1'b1;
              end else begin
                r.tv = 1'b1;
                r.tf = nf[15:0];
              end
            end
          end
        end
      end
      ACT_QUERY: begin
        span_end = sweep_start + sweep_step * point_count;
        if (run_state == RUN_DONE && it.qfreq >= sweep_start && it.qfreq < span_end) begin
          idx = (it.qfreq - sweep_start) / sweep_step;
          e = point_store[idx % 256];
          r.dv = 1'b1;
          r.lr = level(e[7:0], min_rssi, max_rssi);
          r.ls = level(e[15:8], min_snr, max_snr);
        end
      end
      default: begin
        if (run_state == RUN_DONE && it.pidx < point_count) begin
          e = point_store[it.pidx];
          r.dv = 1'b1;
          r.rr = e[7:0];
          r.rs = e[15:8];
        end
      end
    endcase
    r.state = run_state;
    r.pts = point_count;
    r.first = sweep_start;
    return r;
  endfunction

  // Hold a config write until the block takes it, then mirror it.
  task automatic write_register(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drive one beat; on acceptance queue either the typed or the predicted report.
  task automatic send_item(sweep_item_t it, bit typed, sweep_report_t rep);
    sweep_report_t p;
    while (!calm && $urandom_range(99) < 22) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = it.action;
    s_tdata = {6'd0, it.pidx, it.qfreq, it.stop, it.snr, it.rssi, it.rfreq, it.tdone,
               it.anchor};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = record_step(it);
    expected_reports.push_back(typed ? rep : p);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Let the block drain before touching its registers.
  task automatic wait_drained();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Random item shaped by where the sweep is: mostly well-formed polls with the
  // right frequency while running, queries and raw reads in or just past the span once done.
  function automatic sweep_item_t random_item();
    sweep_item_t it;
    int unsigned r, span;
    it.action = 2'($urandom_range(3));
    it.anchor = 16'($urandom);
    it.tdone = 1'($urandom);
    it.rfreq = 16'($urandom);
    it.rssi = 8'($urandom);
    it.snr = 8'($urandom);
    it.stop = 1'($urandom);
    it.qfreq = 16'($urandom);
    it.pidx = 8'($urandom);
    r = $urandom_range(99);
    if (r < 6) return it;  // noise
    if (run_state == RUN_OFF || r < 12) begin
      it.action = ACT_START;
      if ($urandom_range(3) != 0)
        it.anchor = 16'($urandom_range(band_high, band_low <= band_high ? band_low : band_high));
    end else if (run_state == RUN_ON) begin
      it.action = ACT_POLL;
      it.tdone = ($urandom_range(9) != 0);
      if ($urandom_range(9) != 0) it.rfreq = sweep_freq();
      it.stop = ($urandom_range(39) == 0);
    end else begin
      span = sweep_step * point_count;
      if (r < 55) begin
        it.action = ACT_QUERY;
        it.qfreq = 16'(sweep_start + $urandom_range(span + sweep_step));
      end else if (r < 90) begin
        it.action = ACT_RAW;
        it.pidx = 8'($urandom_range(point_count + 1));
      end
    end
    return it;
  endfunction

  // Compare each beat the sink takes against the oldest expectation.
  always @(posedge clk) begin
    sweep_report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        errors++;
      end else begin
        e = expected_reports.pop_front();
        if (m_tdata[0] !== e.tv) begin
          $error("tune_cmd_valid exp %0d got %0d", e.tv, m_tdata[0]); errors++;
        end
        if (m_tdata[16:1] !== e.tf) begin
          $error("tune_freq exp %0d got %0d", e.tf, m_tdata[16:1]); errors++;
        end
        if (m_tdata[18:17] !== e.state) begin
          $error("scan_state exp %0d got %0d", e.state, m_tdata[18:17]); errors++;
        end
        if (m_tlast !== e.fin) begin
          $error("scan_finished exp %0d got %0d", e.fin, m_tlast); errors++;
        end
        if (m_tdata[19] !== e.dv) begin
          $error("data_valid exp %0d got %0d", e.dv, m_tdata[19]); errors++;
        end
        if (m_tdata[27:20] !== e.rr) begin
          $error("raw_rssi exp %0d got %0d", e.rr, m_tdata[27:20]); errors++;
        end
        if (m_tdata[35:28] !== e.rs) begin
          $error("raw_snr exp %0d got %0d", e.rs, m_tdata[35:28]); errors++;
        end
        if (m_tdata[51:36] !== e.lr) begin
          $error("rssi_level exp %0d got %0d", e.lr, m_tdata[51:36]); errors++;
        end
        if (m_tdata[67:52] !== e.ls) begin
          $error("snr_level exp %0d got %0d", e.ls, m_tdata[67:52]); errors++;
        end
        if (m_tdata[76:68] !== e.pts) begin
          $error("points_taken exp %0d got %0d", e.pts, m_tdata[76:68]); errors++;
        end
        if (m_tdata[92:77] !== e.first) begin
          $error("first_freq exp %0d got %0d", e.first, m_tdata[92:77]); errors++;
        end
      end
    end
  end

  // Sink side: stall at random except during the calm stretch.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = calm || ($urandom_range(99) >= 22);
    end
  end

  initial begin
    sweep_row_t rows [$];
    sweep_item_t it;
    sweep_report_t z;
    logic [15:0] phase_cfg [6][5];
    errors = 0;
    calm = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_START;
    cfg_valid = 1'b0;
    cfg_index = CFG_BAND_LOW;
    cfg_data = '0;
    band_low = 16'd0; band_high = 16'hffff; scan_step = 10'd10;
    point_limit = 9'd200; anchor_mode = 1'b0;
    run_state = RUN_OFF; sweep_start = '0; point_count = '0;
    min_rssi = 8'hff; max_rssi = '0; min_snr = 8'hff; max_snr = '0;
    sweep_step = 1; sweep_limit = 0;
    foreach (point_store[i]) point_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at reset defaults: centred sweep of 200 points, step 10.
    z = '{default: '0};
    it = '{default: '0};
    it.action = ACT_QUERY;                        // query before any sweep
    rows.push_back('{it, 1'b1, z});
    it.action = ACT_RAW;                          // raw read before any sweep
    rows.push_back('{it, 1'b1, z});
    it.action = ACT_POLL; it.tdone = 1'b1;        // poll while off
    rows.push_back('{it, 1'b1, z});
    it = '{default: '0}; it.action = ACT_START; it.anchor = 16'd1000;
    z.state = RUN_ON;                             // centred on 1000 lands on 0
    rows.push_back('{it, 1'b1, z});
    it = '{default: '0}; it.action = ACT_POLL;    // tuning not finished
    rows.push_back('{it, 1'b1, z});
    it.tdone = 1'b1; it.rfreq = 16'd5;            // radio off frequency: retune
    z.tv = 1'b1; z.tf = 16'd0;
    rows.push_back('{it, 1'b1, z});
    it.rfreq = 16'd0; it.rssi = 8'hff; it.snr = 8'h00;
    z.tf = 16'd10; z.pts = 9'd1;
    rows.push_back('{it, 1'b1, z});
    it.rfreq = 16'd10; it.rssi = 8'h00; it.snr = 8'hff; it.stop = 1'b1;
    z = '{default: '0}; z.state = RUN_DONE; z.fin = 1'b1; z.pts = 9'd2;
    rows.push_back('{it, 1'b1, z});               // stop request ends the sweep
    z.fin = 1'b0;
    it = '{default: '0}; it.action = ACT_QUERY; it.qfreq = 16'd0;
    z.dv = 1'b1; z.lr = 16'd65280;
    rows.push_back('{it, 1'b1, z});
    it.qfreq = 16'd10; z.lr = 16'd0; z.ls = 16'd65280;
    rows.push_back('{it, 1'b1, z});
    it.qfreq = 16'd20; z = '{default: '0}; z.state = RUN_DONE; z.pts = 9'd2;
    rows.push_back('{it, 1'b1, z});               // just past the span
    it = '{default: '0}; it.action = ACT_RAW; it.pidx = 8'd1;
    z.dv = 1'b1; z.rs = 8'hff;
    rows.push_back('{it, 1'b1, z});
    it.pidx = 8'd2; z.dv = 1'b0; z.rs = 8'h00;
    rows.push_back('{it, 1'b1, z});
    it.pidx = 8'hff; rows.push_back('{it, 1'b1, z});
    it = '{default: '1}; it.action = ACT_START;   // top anchor, fit below band top
    rows.push_back('{it, 1'b0, z});
    it = '{default: '1}; it.action = ACT_POLL;    // all-ones poll, wrong frequency
    rows.push_back('{it, 1'b0, z});
    it = '{default: '0}; it.action = ACT_START;   // bottom anchor clamps to band
    rows.push_back('{it, 1'b0, z});
    it.action = ACT_POLL; it.tdone = 1'b1;
    rows.push_back('{it, 1'b0, z});
    it.action = ACT_START;                        // restart while running
    rows.push_back('{it, 1'b0, z});
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].rep);

    // Register settings per phase: band_low, band_high, step, limit, mode.
    phase_cfg[0] = '{16'd0, 16'hffff, 16'd1000, 16'd256, 16'd1};
    phase_cfg[1] = '{16'd40000, 16'd40100, 16'd1, 16'd1, 16'd0};
    phase_cfg[2] = '{16'd8750, 16'd10800, 16'd7, 16'd256, 16'd0};
    phase_cfg[3] = '{16'hffff, 16'hffff, 16'd1, 16'd5, 16'd1};
    phase_cfg[4] = '{16'd500, 16'd1700, 16'd9, 16'd30, 16'd0};
    phase_cfg[5] = '{16'd0, 16'd300, 16'd1000, 16'd3, 16'd1};
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      if (ph < 6) begin
        for (int k = 0; k < 5; k++) write_register(3'(k), phase_cfg[ph][k]);
      end else begin
        write_register(CFG_BAND_LOW, 16'($urandom_range(30000)));
        write_register(CFG_BAND_HIGH, 16'($urandom_range(65535, 30000)));
        write_register(CFG_SCAN_STEP, 16'($urandom_range(1000, 1)));
        write_register(CFG_POINT_LIMIT, 16'($urandom_range(256, 1)));
        write_register(CFG_ANCHOR_MODE, 16'($urandom_range(1)));
      end
      calm = (ph == 2);                           // long stretch with no idling
      repeat (70) send_item(random_item(), 1'b0, z);
    end
    calm = 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
